[rtl/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Types, codes and sizes shared by the chained hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int MAX_BUCKETS  = 1024;
    localparam int POOL_ENTRIES = 4096;

    localparam int BKT_W   = $clog2(MAX_BUCKETS);
    localparam int DIV_W   = $clog2(MAX_BUCKETS) + 1;
    localparam int IDX_W   = $clog2(POOL_ENTRIES) + 1;
    localparam int PIDX_W  = $clog2(POOL_ENTRIES);
    localparam int CFG_W   = 11;
    localparam int TOTAL_W = 13;

    localparam int KEY_W      = 64;
    localparam int DIGIT_BITS = 4;
    localparam int DIV_STEPS  = KEY_W / DIGIT_BITS;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    localparam logic [IDX_W-1:0] NIL_LINK = IDX_W'(POOL_ENTRIES);

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_PUT    = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_TAKE   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] value_size;
        logic        owned;
    } chm_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [63:0]        found_value;
        logic [31:0]        found_size;
        logic               release_valid;
        logic [63:0]        release_value;
        logic [TOTAL_W-1:0] entry_total;
    } chm_out_t;

    typedef struct packed {
        chm_in_t          item;
        logic [BKT_W-1:0] bucket;
    } chm_cmd_t;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] size;
        logic        owned;
    } chm_entry_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_HEAD,
        BK_WALK,
        BK_ENTRY,
        BK_UNLINK,
        BK_ALLOC,
        BK_INSERT,
        BK_LINK,
        BK_DONE
    } back_state_t;

endpackage

[rtl/chm_ram.sv]
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/chm_front.sv]
// ----------------------------------------------------------------------------
// chm_front
// Accepts items and reduces the key modulo the bucket count, four bits a cycle.
// ----------------------------------------------------------------------------
module chm_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  init_done,
    input  logic [chm_pkg::CFG_W-1:0] bucket_count,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  chm_pkg::chm_in_t      s_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output chm_pkg::chm_cmd_t     q_data
);
    import chm_pkg::*;

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    chm_in_t           item_reg, item_next;
    logic [KEY_W-1:0]  key_sh_reg, key_sh_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [DIV_W-1:0]  div_clamped;
    logic [DIV_W:0]    trial;
    logic [DIV_W-1:0]  rem_work;
    logic              div_done;

    // Zero acts as one bucket, oversize values as the largest count
    always_comb begin
        if (bucket_count == '0) begin
            div_clamped = DIV_W'(1);
        end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
            div_clamped = DIV_W'(MAX_BUCKETS);
        end else begin
            div_clamped = DIV_W'(bucket_count);
        end
    end

    assign div_done = (cnt_reg == CNT_W'(DIV_STEPS));
    assign s_ready  = init_done && !busy_reg;
    assign q_valid  = busy_reg && div_done;
    assign q_data   = '{item: item_reg, bucket: rem_reg[BKT_W-1:0]};

    always_comb begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        item_next   = item_reg;
        key_sh_next = key_sh_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        rem_work    = rem_reg;
        trial       = '0;

        if (s_valid && s_ready) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            item_next   = s_data;
            key_sh_next = s_data.key;
            rem_next    = '0;
            div_next    = div_clamped;
        end else if (busy_reg && !div_done) begin
            // restoring division, one key bit per step
            for (int i = 0; i < DIGIT_BITS; i++) begin
                trial = {rem_work, key_sh_reg[KEY_W-1-i]};
                if (trial >= {1'b0, div_reg}) begin
                    trial = trial - {1'b0, div_reg};
                end
                rem_work = trial[DIV_W-1:0];
            end
            rem_next    = rem_work;
            key_sh_next = key_sh_reg << DIGIT_BITS;
            cnt_next    = cnt_reg + CNT_W'(1);
        end else if (q_valid && q_ready) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        item_reg   <= item_next;
        key_sh_reg <= key_sh_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
    end
endmodule

[rtl/chm_queue.sv]
// ----------------------------------------------------------------------------
// chm_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module chm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  chm_pkg::chm_cmd_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output chm_pkg::chm_cmd_t out_data
);
    import chm_pkg::*;

    chm_cmd_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule

[rtl/chm_back.sv]
// ----------------------------------------------------------------------------
// chm_back
// Walks bucket chains in the entry pool and carries out each command.
// ----------------------------------------------------------------------------
module chm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  chm_pkg::chm_cmd_t q_data,
    output logic              init_done,
    output logic              m_valid,
    input  logic              m_ready,
    output chm_pkg::chm_out_t m_data
);
    import chm_pkg::*;

    back_state_t        st_reg, st_next;
    chm_cmd_t           cmd_reg, cmd_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   prev_reg, prev_next;
    logic [IDX_W-1:0]   new_idx_reg, new_idx_next;
    logic [IDX_W-1:0]   free_head_reg, free_head_next;
    logic [IDX_W-1:0]   mark_reg, mark_next;
    logic [IDX_W-1:0]   count_reg, count_next;
    logic [BKT_W-1:0]   clr_addr_reg, clr_addr_next;
    logic               clr_is_op_reg, clr_is_op_next;
    logic               init_done_reg, init_done_next;
    chm_out_t           res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    chm_out_t           m_data_reg, m_data_next;

    // memory ports
    logic               head_we;
    logic [BKT_W-1:0]   head_waddr, head_raddr;
    logic [IDX_W-1:0]   head_wdata, head_rdata;
    logic               ent_we;
    logic [PIDX_W-1:0]  ent_waddr, ent_raddr;
    chm_entry_t         ent_wdata, ent_rdata;
    logic               link_we;
    logic [PIDX_W-1:0]  link_waddr, link_raddr;
    logic [IDX_W-1:0]   link_wdata, link_rdata;

    chm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BUCKETS)) u_heads (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    chm_ram #(.WIDTH($bits(chm_entry_t)), .DEPTH(POOL_ENTRIES)) u_entries (
        .aclk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    chm_ram #(.WIDTH(IDX_W), .DEPTH(POOL_ENTRIES)) u_links (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );

    assign init_done = init_done_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        st_next        = st_reg;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        new_idx_next   = new_idx_reg;
        free_head_next = free_head_reg;
        mark_next      = mark_reg;
        count_next     = count_reg;
        clr_addr_next  = clr_addr_reg;
        clr_is_op_next = clr_is_op_reg;
        init_done_next = init_done_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        q_ready        = 1'b0;

        head_we    = 1'b0;
        head_waddr = cmd_reg.bucket;
        head_wdata = NIL_LINK;
        head_raddr = q_data.bucket;
        ent_we     = 1'b0;
        ent_waddr  = cur_reg[PIDX_W-1:0];
        ent_wdata  = '{key: cmd_reg.item.key, value: cmd_reg.item.value,
                       size: cmd_reg.item.value_size, owned: cmd_reg.item.owned};
        ent_raddr  = cur_reg[PIDX_W-1:0];
        link_we    = 1'b0;
        link_waddr = cur_reg[PIDX_W-1:0];
        link_wdata = NIL_LINK;
        link_raddr = cur_reg[PIDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (st_reg)
            BK_CLEAR: begin
                head_we       = 1'b1;
                head_waddr    = clr_addr_reg;
                head_wdata    = NIL_LINK;
                clr_addr_next = clr_addr_reg + BKT_W'(1);
                if (clr_addr_reg == BKT_W'(MAX_BUCKETS - 1)) begin
                    free_head_next = '0;
                    mark_next      = '0;
                    count_next     = '0;
                    init_done_next = 1'b1;
                    st_next        = clr_is_op_reg ? BK_DONE : BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_valid && !m_valid_reg) begin
                    q_ready        = 1'b1;
                    cmd_next       = q_data;
                    res_next       = '0;
                    prev_next      = NIL_LINK;
                    if (q_data.item.op == OP_CLEAR) begin
                        clr_addr_next  = '0;
                        clr_is_op_next = 1'b1;
                        st_next        = BK_CLEAR;
                    end else if (q_data.item.op > OP_CLEAR) begin
                        st_next = BK_DONE;
                    end else begin
                        st_next = BK_HEAD;
                    end
                end
            end
            BK_HEAD: begin
                cur_next = head_rdata;
                st_next  = BK_WALK;
            end
            BK_WALK: begin
                if (cur_reg >= NIL_LINK) begin
                    if (cmd_reg.item.op != OP_PUT) begin
                        res_next.status = STAT_MISS;
                        st_next         = BK_DONE;
                    end else if (free_head_reg == mark_reg) begin
                        if (mark_reg >= NIL_LINK) begin
                            res_next.status = STAT_FULL;
                            st_next         = BK_DONE;
                        end else begin
                            new_idx_next   = mark_reg;
                            mark_next      = mark_reg + IDX_W'(1);
                            free_head_next = mark_reg + IDX_W'(1);
                            st_next        = BK_INSERT;
                        end
                    end else if (free_head_reg >= NIL_LINK) begin
                        res_next.status = STAT_FULL;
                        st_next         = BK_DONE;
                    end else begin
                        // fetch the successor of the free list head
                        link_raddr = free_head_reg[PIDX_W-1:0];
                        st_next    = BK_ALLOC;
                    end
                end else begin
                    st_next = BK_ENTRY;
                end
            end
            BK_ENTRY: begin
                if (ent_rdata.key == cmd_reg.item.key) begin
                    res_next.found = 1'b1;
                    if (cmd_reg.item.op == OP_LOOKUP || cmd_reg.item.op == OP_TAKE) begin
                        res_next.found_value = ent_rdata.value;
                        res_next.found_size  = ent_rdata.size;
                    end
                    if ((cmd_reg.item.op == OP_PUT || cmd_reg.item.op == OP_DELETE)
                        && ent_rdata.owned) begin
                        res_next.release_valid = 1'b1;
                        res_next.release_value = ent_rdata.value;
                    end
                    if (cmd_reg.item.op == OP_PUT) begin
                        ent_we  = 1'b1;
                        st_next = BK_DONE;
                    end else if (cmd_reg.item.op == OP_LOOKUP) begin
                        st_next = BK_DONE;
                    end else begin
                        // bypass the entry in its chain
                        if (prev_reg < NIL_LINK) begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg[PIDX_W-1:0];
                            link_wdata = link_rdata;
                        end else begin
                            head_we    = 1'b1;
                            head_wdata = link_rdata;
                        end
                        st_next = BK_UNLINK;
                    end
                end else begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                    st_next   = BK_WALK;
                end
            end
            BK_UNLINK: begin
                link_we        = 1'b1;
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
                if (count_reg != '0) begin
                    count_next = count_reg - IDX_W'(1);
                end
                st_next = BK_DONE;
            end
            BK_ALLOC: begin
                new_idx_next   = free_head_reg;
                free_head_next = link_rdata;
                st_next        = BK_INSERT;
            end
            BK_INSERT: begin
                ent_we     = 1'b1;
                ent_waddr  = new_idx_reg[PIDX_W-1:0];
                link_we    = 1'b1;
                link_waddr = new_idx_reg[PIDX_W-1:0];
                link_wdata = NIL_LINK;
                count_next = count_reg + IDX_W'(1);
                st_next    = BK_LINK;
            end
            BK_LINK: begin
                // append at the chain tail
                if (prev_reg < NIL_LINK) begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[PIDX_W-1:0];
                    link_wdata = new_idx_reg;
                end else begin
                    head_we    = 1'b1;
                    head_wdata = new_idx_reg;
                end
                st_next = BK_DONE;
            end
            BK_DONE: begin
                m_valid_next            = 1'b1;
                m_data_next             = res_reg;
                m_data_next.entry_total = TOTAL_W'(count_reg);
                st_next                 = BK_IDLE;
            end
            default: begin
                st_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= BK_CLEAR;
            free_head_reg <= '0;
            mark_reg      <= '0;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            clr_is_op_reg <= 1'b0;
            init_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st_reg        <= st_next;
            free_head_reg <= free_head_next;
            mark_reg      <= mark_next;
            count_reg     <= count_next;
            clr_addr_reg  <= clr_addr_next;
            clr_is_op_reg <= clr_is_op_next;
            init_done_reg <= init_done_next;
            m_valid_reg   <= m_valid_next;
        end
        cmd_reg     <= cmd_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        new_idx_reg <= new_idx_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end
endmodule

[rtl/chained_hash_map_engine.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Hash map of 64-bit keys with chained buckets over a pooled entry store.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the bucket head memory and takes no item
// until that is done; a clear op runs the same sweep before its result
// comes. The front reduces each key modulo the bucket count, four bits a
// cycle, and hands it to a two-entry queue when the division is done,
// holding it while the queue is full; it takes no new item until the last
// has gone into the queue. The back reads the bucket head, then walks the
// chain through BK_WALK and BK_ENTRY for each entry visited. A found lookup
// or put ends at the matching entry, a found delete or take goes on through
// BK_UNLINK, and a put of a new key goes through BK_INSERT and BK_LINK, with
// BK_ALLOC first when the entry comes off the free list. A result waiting
// on m_ready holds the back, while the front keeps dividing. Write
// bucket_count only while idle.
module chained_hash_map_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  chm_pkg::chm_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output chm_pkg::chm_out_t          m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [chm_pkg::CFG_W-1:0]  cfg_data
);
    import chm_pkg::*;

    logic [CFG_W-1:0] bucket_count_reg, bucket_count_next;
    logic             init_done;
    logic             fq_valid, fq_ready, bq_valid, bq_ready;
    chm_cmd_t         fq_data, bq_data;

    assign cfg_ready         = 1'b1;
    assign bucket_count_next = (cfg_valid && cfg_ready) ? cfg_data : bucket_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= CFG_W'(5);
        end else begin
            bucket_count_reg <= bucket_count_next;
        end
    end

    chm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .init_done(init_done),
        .bucket_count(bucket_count_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    chm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
    );

    chm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
        .init_done(init_done),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
